### rtl/isni_pkg.sv
// Package for the ISNI check character validator: item types, character codes,
// length limits and the small mod-11 helpers. No dependencies.
package isni_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] DIGIT_SPAN = 8'd10;

   localparam logic [3:0] DIGIT_COUNT = 4'd15;
   localparam logic [3:0] MODULUS     = 4'd11;
   // Characters counted before the final one; the total length is this plus one.
   localparam logic [4:0] CHARS_SAT   = 5'd20;
   localparam logic [4:0] CHARS_MIN   = 5'd15;
   localparam logic [4:0] CHARS_MAX   = 5'd18;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_final;
   } req_item_type;

   typedef struct packed {
      logic       format_ok;
      logic [7:0] expected_check;
      logic       check_mismatch;
   } rsp_item_type;

   // One fold step: ((acc + digit) * 2) mod 11, with acc and digit below 11.
   function automatic logic [3:0] fold_step(input logic [3:0] acc, input logic [3:0] digit);
      logic [4:0] sum;
      logic [4:0] dbl;
      sum = {1'b0, acc} + {1'b0, digit};
      if (sum >= {1'b0, MODULUS}) begin
         sum = sum - {1'b0, MODULUS};
      end
      dbl = {sum[3:0], 1'b0};
      if (dbl >= {1'b0, MODULUS}) begin
         dbl = dbl - {1'b0, MODULUS};
      end
      return dbl[3:0];
   endfunction

   // Expected check character for the folded value: (1 - acc) mod 11 as ASCII.
   function automatic logic [7:0] check_char(input logic [3:0] acc);
      logic [3:0] v;
      v = (acc <= 4'd1) ? (4'd1 - acc) : (MODULUS + 4'd1 - acc);
      return (v < 4'd10) ? (CHAR_ZERO + {4'd0, v}) : CHAR_X;
   endfunction

endpackage

### rtl/isni_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on isni_pkg for the payload widths.
interface isni_req_if;
   import isni_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_final;

   modport source (output valid, output char_code, output is_final, input ready);
   modport sink (input valid, input char_code, input is_final, output ready);
endinterface

interface isni_rsp_if;
   import isni_pkg::*;
   logic       valid;
   logic       ready;
   logic       format_ok;
   logic [7:0] expected_check;
   logic       check_mismatch;

   modport source (output valid, output format_ok, output expected_check,
                   output check_mismatch, input ready);
   modport sink (input valid, input format_ok, input expected_check,
                 input check_mismatch, output ready);
endinterface

### rtl/isni_acc.sv
// Running state of one identifier string: mod-11 accumulator, digit and length
// counters, bad character flag. Forms the result for the final character. Uses isni_pkg.
module isni_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  isni_pkg::req_item_type item,
   output isni_pkg::rsp_item_type result
);
   import isni_pkg::*;

   logic [3:0] acc_ff, acc_in;
   logic [3:0] digits_ff, digits_in;
   logic [4:0] chars_ff, chars_in;
   logic       bad_ff, bad_in;
   logic [7:0] digit_val;
   logic       is_digit;
   logic       ok;
   logic [7:0] expect_char;

   assign digit_val   = item.char_code ^ CHAR_ZERO;
   assign is_digit    = digit_val < DIGIT_SPAN;
   assign ok          = (chars_ff >= CHARS_MIN) && (chars_ff <= CHARS_MAX) && !bad_ff;
   assign expect_char = check_char(acc_ff);

   always_comb begin
      result.format_ok      = ok;
      result.expected_check = ok ? expect_char : 8'd0;
      result.check_mismatch = ok && (expect_char != item.char_code);
   end

   always_comb begin
      acc_in    = acc_ff;
      digits_in = digits_ff;
      chars_in  = chars_ff;
      bad_in    = bad_ff;
      if (step_en) begin
         if (item.is_final) begin
            // The string ends here; start clean for the next one.
            acc_in    = 4'd0;
            digits_in = 4'd0;
            chars_in  = 5'd0;
            bad_in    = 1'b0;
         end else begin
            if (chars_ff < CHARS_SAT) begin
               chars_in = chars_ff + 5'd1;
            end
            // After fifteen digits the rest before the final character is only counted.
            if ((digits_ff < DIGIT_COUNT) && (item.char_code != CHAR_SPACE)) begin
               if (is_digit) begin
                  acc_in    = fold_step(acc_ff, digit_val[3:0]);
                  digits_in = digits_ff + 4'd1;
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 4'd0;
         digits_ff <= 4'd0;
         chars_ff  <= 5'd0;
         bad_ff    <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         chars_ff  <= chars_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

### rtl/isni_check_digit_validator.sv
// ISNI check character validator (ISO 7064 MOD 11-2). Feed an identifier one byte
// per item with is_final set on the check character; one response comes out per
// string, at its final character. An item is taken every cycle unless the input
// side is held; an accepted final character reaches the response through an input
// register and a response register. Only a final item that meets a full, stalled
// response register holds the input side; non-final items always flow on.
// Depends on isni_pkg, isni_req_if, isni_rsp_if and isni_acc.
module isni_check_digit_validator (
   input logic       clock,
   input logic       reset,
   isni_req_if.sink   req_ch,
   isni_rsp_if.source rsp_ch
);
   import isni_pkg::*;

   req_item_type s1_ff, s1_in;
   logic         s1_valid_ff, s1_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type result;
   logic         s1_adv;
   logic         req_take;
   logic         rsp_load;

   assign s1_adv   = s1_valid_ff && (!s1_ff.is_final || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_load = s1_adv && s1_ff.is_final;

   isni_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_adv),
      .item    (s1_ff),
      .result  (result)
   );

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_in.char_code = req_ch.char_code;
         s1_in.is_final  = req_ch.is_final;
         s1_valid_in     = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.format_ok      = rsp_ff.format_ok;
   assign rsp_ch.expected_check = rsp_ff.expected_check;
   assign rsp_ch.check_mismatch = rsp_ff.check_mismatch;

   // A rejected string reports no check character and no mismatch.
   a_bad_format_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.format_ok |-> (rsp_ff.expected_check == 8'd0) &&
                                            !rsp_ff.check_mismatch)
      else $error("bad format response carries check data");

   // A good string always reports a digit or X.
   a_check_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.format_ok |->
         ((rsp_ff.expected_check >= CHAR_ZERO) &&
          (rsp_ff.expected_check < CHAR_ZERO + DIGIT_SPAN)) ||
         (rsp_ff.expected_check == CHAR_X))
      else $error("expected check character out of range");

   // An item held in the input register is neither dropped nor altered while blocked.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_ff))
      else $error("blocked item lost from input register");

endmodule
